FILE: rtl/day_count_to_calendar_date_top_defines.svh
// assertion macros for the day count to calendar date block
`ifndef DAY_COUNT_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define DAY_COUNT_TO_CALENDAR_DATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define DCCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("dccd assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("dccd assertion failed");

`else

`define DCCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DCCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/dccd_pkg.sv
// shared types, constants and month table for the day count to calendar date block
`default_nettype none

package dccd_pkg;

	// input beat
	typedef struct packed {
		logic [15:0] day_count;
		logic [10:0] minute_of_day;
		logic [11:0] tick_in_minute;
	} req_t;

	// result beat
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} rsp_t;

	// sequencer status seen by the top level
	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	// working value width of the shared subtract unit
	localparam int unsigned ACC_W = 17;

	localparam logic [ACC_W-1:0] EPOCH_SHIFT_DAYS = 17'd731;
	localparam logic [ACC_W-1:0] QUAD_DAYS        = 17'd1461;
	localparam logic [ACC_W-1:0] COMMON_YEAR_DAYS = 17'd365;
	localparam logic [ACC_W-1:0] LEAP_YEAR_DAYS   = 17'd366;
	localparam logic [ACC_W-1:0] TICKS_PER_SECOND = 17'd50;
	localparam logic [ACC_W-1:0] SIXTY            = 17'd60;
	localparam logic [11:0]      BASE_YEAR        = 12'd1976;
	localparam logic [4:0]       FEB_BASE_DAYS    = 5'd28;

	// index of december, the month walk never goes past it
	localparam logic [3:0] LAST_MONTH = 4'd11;

	// top bit position of each restoring division
	localparam logic [2:0] QUAD_TOP_BIT = 3'd5;
	localparam logic [2:0] HOUR_TOP_BIT = 3'd5;
	localparam logic [2:0] SEC_TOP_BIT  = 3'd6;

	// month length, february follows the leap flag
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd1: len = FEB_BASE_DAYS + {4'b0, leap};
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dccd_sub_unit.sv
// shared subtract and compare unit
`default_nettype none

module dccd_sub_unit (
	input  wire logic [dccd_pkg::ACC_W-1:0] a,
	input  wire logic [dccd_pkg::ACC_W-1:0] b,
	output logic      [dccd_pkg::ACC_W-1:0] diff,
	output logic                            ge
);

	logic [dccd_pkg::ACC_W:0] wide;

	// one wide subtract, borrow out gives the compare
	always_comb begin
		wide = {1'b0, a} - {1'b0, b};
		diff = wide[dccd_pkg::ACC_W-1:0];
		ge   = ~wide[dccd_pkg::ACC_W];
	end

endmodule

`default_nettype wire

FILE: rtl/dccd_seq.sv
// sequencer and working registers around the shared subtract unit
`default_nettype none

module dccd_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire dccd_pkg::req_t       req,
	input  wire logic                 take,
	output dccd_pkg::seq_status_t     status,
	output dccd_pkg::rsp_t            rsp
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_QUAD   = 9'b000000010,
		ST_LEAP   = 9'b000000100,
		ST_YEAR   = 9'b000001000,
		ST_MONTH  = 9'b000010000,
		ST_HOUR   = 9'b000100000,
		ST_SEC    = 9'b001000000,
		ST_SECMOD = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [2:0] cnt_q;

	logic [dccd_pkg::ACC_W-1:0] acc_q;
	logic [6:0]  quot_q;
	logic [10:0] mins_q;
	logic [11:0] ticks_q;
	logic [11:0] year_q;
	logic        leap_q;
	logic [3:0]  mon_q;
	logic [4:0]  dom_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;

	logic [dccd_pkg::ACC_W-1:0] sub_b;
	logic [dccd_pkg::ACC_W-1:0] sub_diff;
	logic                       sub_ge;
	logic [6:0]                 quot_next;
	logic [dccd_pkg::ACC_W-1:0] rem;
	logic                       month_last;

	// subtrahend select for the current step
	always_comb begin
		unique case (state_q)
			ST_QUAD:   sub_b = dccd_pkg::QUAD_DAYS << cnt_q;
			ST_LEAP:   sub_b = dccd_pkg::LEAP_YEAR_DAYS;
			ST_YEAR:   sub_b = dccd_pkg::COMMON_YEAR_DAYS;
			ST_MONTH:  sub_b = {{(dccd_pkg::ACC_W-5){1'b0}},
				dccd_pkg::month_len(mon_q, leap_q)};
			ST_HOUR:   sub_b = dccd_pkg::SIXTY << cnt_q;
			ST_SEC:    sub_b = dccd_pkg::TICKS_PER_SECOND << cnt_q;
			ST_SECMOD: sub_b = dccd_pkg::SIXTY;
			default:   sub_b = '0;
		endcase
	end

	dccd_sub_unit u_sub (
		.a    (acc_q),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// restoring division step values
	assign quot_next  = {quot_q[5:0], sub_ge};
	assign rem        = sub_ge ? sub_diff : acc_q;
	assign month_last = !sub_ge || (mon_q == dccd_pkg::LAST_MONTH);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_QUAD;
						cnt_q   <= dccd_pkg::QUAD_TOP_BIT;
					end
				end
				ST_QUAD: begin
					if (cnt_q == 3'd0) begin
						state_q <= ST_LEAP;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				ST_LEAP: begin
					state_q <= sub_ge ? ST_YEAR : ST_MONTH;
				end
				ST_YEAR: begin
					if (!sub_ge) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (month_last) begin
						state_q <= ST_HOUR;
						cnt_q   <= dccd_pkg::HOUR_TOP_BIT;
					end
				end
				ST_HOUR: begin
					if (cnt_q == 3'd0) begin
						state_q <= ST_SEC;
						cnt_q   <= dccd_pkg::SEC_TOP_BIT;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				ST_SEC: begin
					if (cnt_q == 3'd0) begin
						state_q <= ST_SECMOD;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				ST_SECMOD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					acc_q   <= {1'b0, req.day_count} + dccd_pkg::EPOCH_SHIFT_DAYS;
					quot_q  <= '0;
					mins_q  <= req.minute_of_day;
					ticks_q <= req.tick_in_minute;
				end
			end
			// four-year cycles, then cycle start year
			ST_QUAD: begin
				acc_q  <= rem;
				quot_q <= quot_next;
				if (cnt_q == 3'd0) begin
					year_q <= dccd_pkg::BASE_YEAR + {4'b0, quot_next[5:0], 2'b00};
				end
			end
			// leap year at the head of the cycle
			ST_LEAP: begin
				leap_q <= !sub_ge;
				mon_q  <= '0;
				if (sub_ge) begin
					acc_q  <= sub_diff;
					year_q <= year_q + 12'd1;
				end
			end
			// common years that follow
			ST_YEAR: begin
				if (sub_ge) begin
					acc_q  <= sub_diff;
					year_q <= year_q + 12'd1;
				end
			end
			// month walk, then load minutes
			ST_MONTH: begin
				if (!month_last) begin
					acc_q <= sub_diff;
					mon_q <= mon_q + 4'd1;
				end else begin
					dom_q  <= acc_q[4:0] + 5'd1;
					acc_q  <= {{(dccd_pkg::ACC_W-11){1'b0}}, mins_q};
					quot_q <= '0;
				end
			end
			// minutes over sixty, then load ticks
			ST_HOUR: begin
				if (cnt_q == 3'd0) begin
					hour_q   <= quot_next[4:0];
					minute_q <= rem[5:0];
					acc_q    <= {{(dccd_pkg::ACC_W-12){1'b0}}, ticks_q};
					quot_q   <= '0;
				end else begin
					acc_q  <= rem;
					quot_q <= quot_next;
				end
			end
			// ticks over fifty
			ST_SEC: begin
				if (cnt_q == 3'd0) begin
					acc_q <= {{(dccd_pkg::ACC_W-7){1'b0}}, quot_next};
				end else begin
					acc_q  <= rem;
					quot_q <= quot_next;
				end
			end
			// seconds wrap at sixty, quotient stays below twice that
			ST_SECMOD: begin
				second_q <= rem[5:0];
			end
			default: begin
			end
		endcase
	end

	// status and result
	always_comb begin
		status.idle       = (state_q == ST_IDLE);
		status.done       = (state_q == ST_DONE);
		rsp.year          = year_q;
		rsp.month         = mon_q + 4'd1;
		rsp.day_of_month  = dom_q;
		rsp.hour          = hour_q;
		rsp.minute        = minute_q;
		rsp.second        = second_q;
	end

endmodule

`default_nettype wire

FILE: rtl/day_count_to_calendar_date_top.sv
// day count to calendar date: iterative converter with output register
// occupancy: one item at a time, the next beat is taken only after the last result is loaded into the output register
// work is serialised through the one subtract unit: 6 quad steps, 1 to 4 year and 1 to
// 12 month steps, 6 hour steps, 7 tick steps, one seconds wrap and one hand-off
// reset: arst_n clears the sequencer and the output valid, no other state
`default_nettype none
`include "day_count_to_calendar_date_top_defines.svh"

module day_count_to_calendar_date_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dccd_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dccd_pkg::rsp_t      rsp
);

	dccd_pkg::seq_status_t status;
	dccd_pkg::rsp_t        seq_rsp;
	logic                  start;
	logic                  rsp_load;
	logic                  rsp_valid_q;
	dccd_pkg::rsp_t        rsp_q;

	// input beat handshake
	assign req_stall = !status.idle;
	assign start     = req_valid && status.idle;

	// output register loads when empty or being drained
	assign rsp_load = status.done && (!rsp_valid_q || !rsp_stall);

	dccd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.take   (rsp_load),
		.status (status),
		.rsp    (seq_rsp)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`DCCD_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, start, !status.idle)
	`DCCD_ASSERT_NEXT(a_done_waits, clk, arst_n, status.done && !rsp_load, status.done)
	`DCCD_ASSERT_IMPL(a_month_range, clk, arst_n, rsp_valid, (rsp.month != 4'd0) && (rsp.month <= 4'd12))
	`DCCD_ASSERT_IMPL(a_day_range, clk, arst_n, rsp_valid, rsp.day_of_month != 5'd0)
	`DCCD_ASSERT_IMPL(a_time_range, clk, arst_n, rsp_valid, (rsp.minute < 6'd60) && (rsp.second < 6'd60))

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the day count to calendar date converter
`timescale 1ns / 100ps

module tb;

	// calendar arithmetic constants
	localparam bit [31:0] SHIFT_TO_1976   = 32'd731;
	localparam bit [31:0] FOUR_YEAR_DAYS  = 32'd1461;
	localparam bit [31:0] FIRST_YEAR      = 32'd1976;
	localparam bit [31:0] COMMON_DAYS     = 32'd365;
	localparam bit [31:0] LEAP_DAYS       = 32'd366;
	localparam bit [31:0] FEB_DAYS        = 32'd28;
	localparam bit [31:0] TICKS_PER_SEC   = 32'd50;
	localparam bit [31:0] BASE_SIXTY      = 32'd60;
	localparam int        REPORT_LIMIT    = 10;
	localparam int        IDLE_PERCENT    = 26;
	localparam int        LONG_HOLD       = 300;
	localparam int        TAIL_CYCLES     = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dccd_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dccd_pkg::rsp_t rsp;

	dccd_pkg::req_t stamps_pending[$];
	dccd_pkg::rsp_t dates_due[$];
	int unsigned stamps_offered = 0;
	int unsigned stamps_taken = 0;
	int unsigned date_errors = 0;
	int unsigned hold_left = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;

	day_count_to_calendar_date_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// calendar date and time of day for one timestamp
	function automatic dccd_pkg::rsp_t calendar_of(input dccd_pkg::req_t stamp);
		bit [31:0] days, quads, year, mins, ticks, span, mon, hrs, secs;
		bit leap, found;
		dccd_pkg::rsp_t date;
		days = {16'b0, stamp.day_count} + SHIFT_TO_1976;
		mins = {21'b0, stamp.minute_of_day};
		ticks = {20'b0, stamp.tick_in_minute};
		// four-year cycles, leap year first
		quads = days / FOUR_YEAR_DAYS;
		days = days - quads * FOUR_YEAR_DAYS;
		leap = (days < LEAP_DAYS);
		year = FIRST_YEAR + 4 * quads;
		if (!leap) begin
			days = days - LEAP_DAYS;
			year = year + 1 + days / COMMON_DAYS;
			days = days % COMMON_DAYS;
		end
		// month walk, december takes what is left
		mon = 0;
		found = 1'b0;
		while (mon < 11 && !found) begin
			case (mon) inside
				1: span = FEB_DAYS + {31'b0, leap};
				3, 5, 8, 10: span = 30;
				default: span = 31;
			endcase
			if (days < span) begin
				found = 1'b1;
			end else begin
				days = days - span;
				mon = mon + 1;
			end
		end
		mon = mon + 1;
		days = days + 1;
		hrs = mins / BASE_SIXTY;
		mins = mins % BASE_SIXTY;
		secs = (ticks / TICKS_PER_SEC) % BASE_SIXTY;
		date.year = year[11:0];
		date.month = mon[3:0];
		date.day_of_month = days[4:0];
		date.hour = hrs[4:0];
		date.minute = mins[5:0];
		date.second = secs[5:0];
		return date;
	endfunction

	task automatic queue_stamp(input int day, input int mins, input int ticks);
		dccd_pkg::req_t stamp;
		stamp.day_count = day[15:0];
		stamp.minute_of_day = mins[10:0];
		stamp.tick_in_minute = ticks[11:0];
		stamps_pending.push_back(stamp);
	endtask

	// random timestamps, mostly in range with some overrange time fields
	task automatic queue_random_stamps(input int count);
		int day, mins, ticks, pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 30)
				day = $urandom_range(3000);
			else if (pick < 40)
				day = $urandom_range(65535, 63000);
			else
				day = $urandom_range(65535);
			mins = ($urandom_range(99) < 12) ? $urandom_range(2047, 1440) : $urandom_range(1439);
			ticks = ($urandom_range(99) < 12) ? $urandom_range(4095, 3000) : $urandom_range(2999);
			queue_stamp(day, mins, ticks);
		end
	endtask

	// sender waits until every beat is taken and every date has come back
	task automatic wait_drained;
		while (stamps_pending.size() != 0 || stamps_taken != stamps_offered ||
				dates_due.size() != 0)
			@(posedge clk);
	endtask

	// input driver, a presented beat is held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (stamps_taken == stamps_offered) begin
			if (stamps_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
				req <= stamps_pending.pop_front();
				req_valid <= 1'b1;
				stamps_offered <= stamps_offered + 1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result stall, random with one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			rsp_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (calm) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// monitor: predict on input beats, check result beats
	always @(posedge clk) begin : monitor
		dccd_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				dates_due.push_back(calendar_of(req));
				stamps_taken <= stamps_taken + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (dates_due.size() == 0) begin
					date_errors++;
					if (date_errors <= REPORT_LIMIT)
						$display("unexpected date beat %0d-%0d-%0d %0d:%0d:%0d",
							rsp.year, rsp.month, rsp.day_of_month,
							rsp.hour, rsp.minute, rsp.second);
				end else begin
					want = dates_due.pop_front();
					if (rsp.year !== want.year || rsp.month !== want.month ||
							rsp.day_of_month !== want.day_of_month ||
							rsp.hour !== want.hour || rsp.minute !== want.minute ||
							rsp.second !== want.second) begin
						date_errors++;
						if (date_errors <= REPORT_LIMIT)
							$display("date mismatch want %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
								want.year, want.month, want.day_of_month,
								want.hour, want.minute, want.second,
								rsp.year, rsp.month, rsp.day_of_month,
								rsp.hour, rsp.minute, rsp.second);
					end
				end
			end
		end
	end

	// run limit
	initial begin
		#1000000;
		$display("tb failed");
		$finish;
	end

	// stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// epoch, top of range, leap day and year boundaries, overrange time fields
		queue_stamp(0, 0, 0);
		queue_stamp(65535, 1439, 2999);
		queue_stamp(65534, 0, 49);
		queue_stamp(729, 59, 49);
		queue_stamp(730, 60, 50);
		queue_stamp(788, 1440, 3000);
		queue_stamp(789, 2047, 4095);
		queue_stamp(790, 1919, 2950);
		queue_stamp(1095, 1920, 3049);
		queue_stamp(1096, 720, 1500);
		queue_stamp(1154, 1380, 2999);
		queue_stamp(1155, 1, 1);
		queue_stamp(2190, 600, 100);
		queue_stamp(2191, 1200, 3500);
		queue_stamp(2250, 30, 2000);
		queue_stamp(8094, 900, 750);
		queue_stamp(44619, 1000, 2500);
		queue_stamp(44620, 1439, 4000);
		queue_stamp(32767, 1023, 2047);
		queue_stamp(32768, 1024, 2048);
		queue_stamp(21845, 682, 1365);
		queue_stamp(43690, 1365, 2730);
		wait_drained;

		// random beats with a long result hold-off at the start
		hold_go = 1'b1;
		queue_random_stamps(450);
		while (stamps_pending.size() != 0)
			@(posedge clk);

		// sender pause, then a stretch with no idling on either side
		wait_drained;
		calm = 1'b1;
		queue_random_stamps(300);
		while (stamps_pending.size() != 0)
			@(posedge clk);
		calm = 1'b0;

		queue_random_stamps(450);
		wait_drained;
		repeat (TAIL_CYCLES) @(posedge clk);

		date_errors += dates_due.size();
		if (date_errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: day_count_to_calendar_date_top.f
+incdir+rtl
rtl/dccd_pkg.sv
rtl/dccd_sub_unit.sv
rtl/dccd_seq.sv
rtl/day_count_to_calendar_date_top.sv
test/tb.sv
